[rtl/bpfr_pkg.sv]
// Shared constants, result codes and controller/datapath interface types
// for the buffer pool frame replacer. No dependencies.
`default_nettype none

package bpfr_pkg;

    localparam int NUM_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 32;

    localparam int PAGE_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int FRAME_OUT_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 1'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EVICT     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    // Replacement mode
    localparam logic MODE_LRU = 1'b0;

    typedef struct packed {
        logic load_in;    // input transfer: capture page and access type
        logic set_oor;    // page out of range: post the refusal result
        logic addr_init;  // start a frame sweep at the highest index
        logic scan_rd;    // read tag and rank for lookup
        logic resolve;    // decide hit / free / eviction, write the stores
        logic upd_rd;     // read rank for the recency update pass
        logic load_out;   // move the pending result into the output register
    } t_cmd;

    typedef struct packed {
        logic out_of_range;
        logic empty;      // no frame loaded yet
        logic last_addr;  // sweep address is the lowest loaded frame
        logic need_upd;   // resolve needs a recency update pass
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

`default_nettype wire

[rtl/bpfr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module bpfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[rtl/bpfr_ctrl.sv]
// Sequencing state machine for the frame replacer: lookup sweep, resolve,
// recency update sweep and result hand-off. Depends on bpfr_pkg.
`default_nettype none

module bpfr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bpfr_pkg::t_sts i_sts,
    output bpfr_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_SDRAIN  = 3'd3;
    localparam logic [2:0] S_RESOLVE = 3'd4;
    localparam logic [2:0] S_UPD     = 3'd5;
    localparam logic [2:0] S_UDRAIN  = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.out_of_range) begin
                    o_cmd.set_oor = 1'b1;
                    n_state       = S_OUT;
                end else if (i_sts.empty) begin
                    n_state = S_RESOLVE;
                end else begin
                    o_cmd.addr_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_SDRAIN;
                end
            end
            S_SDRAIN: begin
                n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                if (i_sts.need_upd) begin
                    o_cmd.addr_init = 1'b1;
                    n_state         = S_UPD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_UPD: begin
                o_cmd.upd_rd = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_UDRAIN;
                end
            end
            S_UDRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/bpfr_dp.sv]
// Datapath of the frame replacer: config registers, tag and rank RAMs,
// dirty bits, sweep address, lookup tracking and result registers.
// Depends on bpfr_pkg and bpfr_ram.
`default_nettype none

module bpfr_dp #(
    parameter int NUM_FRAMES = bpfr_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = bpfr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bpfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bpfr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [bpfr_pkg::PAGE_W-1:0]        i_page,
    input  wire logic                               i_is_write,
    input  wire logic                               i_out_stall,
    input  wire bpfr_pkg::t_cmd                     i_cmd,
    output bpfr_pkg::t_sts                          o_sts,
    output logic                                    o_out_valid,
    output logic [bpfr_pkg::STATUS_W-1:0]           o_status,
    output logic [bpfr_pkg::FRAME_OUT_W-1:0]        o_frame,
    output logic                                    o_fetch,
    output logic                                    o_writeback,
    output logic [bpfr_pkg::PAGE_W-1:0]             o_victim_page
);

    localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
    localparam int TAG_W   = (PAGE_BITS < bpfr_pkg::PAGE_W) ? PAGE_BITS : bpfr_pkg::PAGE_W;
    localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(NUM_FRAMES - 1);
    localparam logic [CNT_W-1:0]   ALL_FREE   = CNT_W'(NUM_FRAMES);

    // Configuration
    logic                        r_mode;
    logic [bpfr_pkg::PAGE_W-1:0] r_page_count;

    // Current access
    logic [bpfr_pkg::PAGE_W-1:0] r_in_page;
    logic                        r_in_wr;

    // Pool state
    logic [CNT_W-1:0]      r_free_left;
    logic [NUM_FRAMES-1:0] r_dirty;

    // Sweep
    logic [FRAME_W-1:0] r_addr;
    logic               r_scan_vld;
    logic               r_upd_vld;
    logic [FRAME_W-1:0] r_eval_f;

    // Lookup tracking
    logic               r_hit;
    logic [FRAME_W-1:0] r_hit_f;
    logic [FRAME_W-1:0] r_hit_rank;
    logic [FRAME_W-1:0] r_lru_f;
    logic [TAG_W-1:0]   r_lru_tag;
    logic [FRAME_W-1:0] r_mru_f;
    logic [TAG_W-1:0]   r_mru_tag;

    // Recency update
    logic [FRAME_W-1:0] r_tgt_f;
    logic [FRAME_W-1:0] r_upd_p;

    // Pending result
    logic [bpfr_pkg::STATUS_W-1:0] r_res_status;
    logic [FRAME_W-1:0]            r_res_frame;
    logic                          r_res_fetch;
    logic                          r_res_wb;
    logic [bpfr_pkg::PAGE_W-1:0]   r_res_vp;

    logic               r_out_valid;

    logic [TAG_W-1:0]   w_tag_rd;
    logic [FRAME_W-1:0] w_rank_rd;
    logic [CNT_W-1:0]   w_busy;
    logic [FRAME_W-1:0] w_busy_m1;
    logic               w_free_avail;
    logic [FRAME_W-1:0] w_new_free_f;
    logic [FRAME_W-1:0] w_vict_f;
    logic [TAG_W-1:0]   w_vict_tag;
    logic [FRAME_W-1:0] w_sel_f;
    logic [FRAME_W-1:0] w_new_rank;
    logic               w_tag_we;
    logic               w_rank_we;
    logic [FRAME_W-1:0] w_rank_wa;
    logic [FRAME_W-1:0] w_rank_wd;

    assign w_busy       = ALL_FREE - r_free_left;
    assign w_busy_m1    = FRAME_W'(w_busy - CNT_W'(1));
    assign w_free_avail = (r_free_left != '0);
    assign w_new_free_f = FRAME_W'(r_free_left - CNT_W'(1));
    assign w_vict_f     = (r_mode == bpfr_pkg::MODE_LRU) ? r_lru_f : r_mru_f;
    assign w_vict_tag   = (r_mode == bpfr_pkg::MODE_LRU) ? r_lru_tag : r_mru_tag;
    assign w_sel_f      = r_hit ? r_hit_f : (w_free_avail ? w_new_free_f : w_vict_f);

    // Move-to-back: ranks above the removed one shift down, target goes last
    assign w_new_rank = (r_eval_f == r_tgt_f) ? w_busy_m1 :
                        (w_rank_rd > r_upd_p) ? (w_rank_rd - FRAME_W'(1)) : w_rank_rd;

    assign w_tag_we  = i_cmd.resolve && !r_hit;
    assign w_rank_we = (i_cmd.resolve && !r_hit && w_free_avail) || r_upd_vld;
    assign w_rank_wa = r_upd_vld ? r_eval_f : w_new_free_f;
    assign w_rank_wd = r_upd_vld ? w_new_rank : FRAME_W'(w_busy);

    bpfr_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_FRAMES)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_we      (w_tag_we),
        .i_wr_addr (w_sel_f),
        .i_wr_data (r_in_page[TAG_W-1:0]),
        .i_rd_addr (r_addr),
        .o_rd_data (w_tag_rd)
    );

    bpfr_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NUM_FRAMES)
    ) u_rank_ram (
        .i_clk     (i_clk),
        .i_we      (w_rank_we),
        .i_wr_addr (w_rank_wa),
        .i_wr_data (w_rank_wd),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rank_rd)
    );

    assign o_sts.out_of_range = (r_in_page >= r_page_count);
    assign o_sts.empty        = (r_free_left == ALL_FREE);
    assign o_sts.last_addr    = (CNT_W'(r_addr) == r_free_left);
    assign o_sts.need_upd     = r_hit || (!w_free_avail && (r_mode == bpfr_pkg::MODE_LRU));
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_page_count <= '0;
            r_free_left  <= ALL_FREE;
            r_dirty      <= '0;
            r_scan_vld   <= 1'b0;
            r_upd_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bpfr_pkg::CFG_REPLACE_MODE: r_mode       <= i_cfg_data[0];
                    bpfr_pkg::CFG_PAGE_COUNT:   r_page_count <= i_cfg_data[bpfr_pkg::PAGE_W-1:0];
                    default: ;
                endcase
            end

            r_scan_vld <= i_cmd.scan_rd;
            r_upd_vld  <= i_cmd.upd_rd;

            if (i_cmd.load_in) begin
                r_hit <= 1'b0;
            end else if (r_scan_vld && (w_tag_rd == r_in_page[TAG_W-1:0])) begin
                r_hit <= 1'b1;
            end

            if (i_cmd.resolve) begin
                if (!r_hit && w_free_avail) begin
                    r_free_left <= r_free_left - CNT_W'(1);
                end
                // A reload starts clean; a write then marks the frame dirty
                if (!r_hit || r_in_wr) begin
                    r_dirty[w_sel_f] <= r_in_wr;
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_page <= i_page;
            r_in_wr   <= i_is_write;
        end

        if (i_cmd.addr_init) begin
            r_addr <= LAST_FRAME;
        end else if (i_cmd.scan_rd || i_cmd.upd_rd) begin
            r_addr <= r_addr - FRAME_W'(1);
        end
        r_eval_f <= r_addr;

        if (r_scan_vld) begin
            if (w_tag_rd == r_in_page[TAG_W-1:0]) begin
                r_hit_f    <= r_eval_f;
                r_hit_rank <= w_rank_rd;
            end
            if (w_rank_rd == '0) begin
                r_lru_f   <= r_eval_f;
                r_lru_tag <= w_tag_rd;
            end
            if (w_rank_rd == w_busy_m1) begin
                r_mru_f   <= r_eval_f;
                r_mru_tag <= w_tag_rd;
            end
        end

        if (i_cmd.set_oor) begin
            r_res_status <= bpfr_pkg::ST_RANGE;
            r_res_frame  <= '0;
            r_res_fetch  <= 1'b0;
            r_res_wb     <= 1'b0;
            r_res_vp     <= '0;
        end else if (i_cmd.resolve) begin
            r_res_frame <= w_sel_f;
            if (r_hit) begin
                r_res_status <= bpfr_pkg::ST_HIT;
                r_res_fetch  <= 1'b0;
                r_res_wb     <= 1'b0;
                r_res_vp     <= '0;
                r_tgt_f      <= r_hit_f;
                r_upd_p      <= r_hit_rank;
            end else if (w_free_avail) begin
                r_res_status <= bpfr_pkg::ST_MISS_FREE;
                r_res_fetch  <= 1'b1;
                r_res_wb     <= 1'b0;
                r_res_vp     <= '0;
            end else begin
                r_res_status <= bpfr_pkg::ST_EVICT;
                r_res_fetch  <= 1'b1;
                r_res_wb     <= r_dirty[w_vict_f];
                r_res_vp     <= r_dirty[w_vict_f] ? bpfr_pkg::PAGE_W'(w_vict_tag) : '0;
                r_tgt_f      <= w_vict_f;
                r_upd_p      <= '0;
            end
        end

        if (i_cmd.load_out) begin
            o_status      <= r_res_status;
            o_frame       <= bpfr_pkg::FRAME_OUT_W'(r_res_frame);
            o_fetch       <= r_res_fetch;
            o_writeback   <= r_res_wb;
            o_victim_page <= r_res_vp;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/buffer_pool_frame_replacer.sv]
// Buffer pool frame replacer, top level: controller plus datapath (bpfr_ctrl, bpfr_dp).
// One access at a time. An out-of-range page goes straight to its refusal result, a miss
// into an empty pool straight to resolve; any other access first sweeps the loaded frames,
// and a second sweep follows when the recency order shifts (hit, least-recent eviction).
// A result held by output stall holds off the next access.
// Synchronous active-low reset: pool empty, config registers zero. Uses bpfr_pkg.
`default_nettype none

module buffer_pool_frame_replacer #(
    parameter int NUM_FRAMES = bpfr_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = bpfr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bpfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bpfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [bpfr_pkg::PAGE_W-1:0]     i_page,
    input  wire logic                            i_is_write,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [bpfr_pkg::STATUS_W-1:0]        o_status,
    output logic [bpfr_pkg::FRAME_OUT_W-1:0]     o_frame,
    output logic                                 o_fetch,
    output logic                                 o_writeback,
    output logic [bpfr_pkg::PAGE_W-1:0]          o_victim_page
);

    bpfr_pkg::t_cmd w_cmd;
    bpfr_pkg::t_sts w_sts;

    bpfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bpfr_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_page        (i_page),
        .i_is_write    (i_is_write),
        .i_out_stall   (i_out_stall),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_frame       (o_frame),
        .o_fetch       (o_fetch),
        .o_writeback   (o_writeback),
        .o_victim_page (o_victim_page)
    );

endmodule

`default_nettype wire
